// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the sorter rtl, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/isrt_pkg.sv =====
// ---------------------------------------------------------------------------
// isrt_pkg
// types and constants of the insertion sorter
// ---------------------------------------------------------------------------
package isrt_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int VALUE_W   = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

	// contents of one cell as seen by its neighbors
	typedef struct packed {
		value_t value;
		logic   valid;
	} cell_data_t;

	// strobes broadcast to every cell
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== hdl/isrt_cell.sv =====
// ---------------------------------------------------------------------------
// isrt_cell
// one compare-and-shift cell of the sorting chain
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module isrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  isrt_pkg::cell_ctrl_t ctrl,
	input  isrt_pkg::value_t     din,
	input  isrt_pkg::cell_data_t left,
	input  logic                left_gt,
	input  isrt_pkg::cell_data_t right,
	output logic                gt,
	output isrt_pkg::cell_data_t data
);
	import isrt_pkg::*;

	value_t value_q;
	logic   valid_q;

	// an empty cell counts as larger than anything
	assign gt   = !valid_q || (value_q > din);
	assign data = '{value: value_q, valid: valid_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right.valid;
		end else if (ctrl.insert && gt) begin
			valid_q <= left_gt ? left.valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right.value;
		end else if (ctrl.insert && gt) begin
			value_q <= left_gt ? left.value : din;
		end
	end

	`ASSERT_NEVER(a_cell_order, clk, arst_n, valid_q && right.valid && (value_q > right.value), "cell chain out of order")
	`ASSERT_NEVER(a_cell_ctrl, clk, arst_n, ctrl.insert && ctrl.shift, "insert and shift together")

endmodule

// ===== hdl/insertion_sorter.sv =====
// ---------------------------------------------------------------------------
// insertion_sorter
// stable ascending sort of a streamed list of signed 32-bit values
// ---------------------------------------------------------------------------
// Values arrive one request per cycle on the slave stream and are inserted
// into a chain of MAX_ITEMS compare-and-shift cells that stays sorted at all
// times: every cell holding a larger value moves up one place, and the new
// value lands just after all equal ones, so equal values keep their arrival
// order. While a list is loading the block takes one request every cycle.
// A request with tlast set ends the list: the chain then shifts down toward
// cell 0 and emits one result per cycle on the master stream (as fast as
// tready allows), with tlast on the final one. The slave side is stalled
// during the drain, until the chain is seen empty. Values arriving while
// all cells are full are dropped, and tuser (overflow) is then set on every
// result of that list. The last result can still be waiting in the output
// register while the next list starts loading.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module insertion_sorter (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: tdata = value[31:0]; tlast = last_in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	// master stream: tdata = sorted_value[31:0]; tlast = last_out; tuser = overflow
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,
	output logic        m_axis_tuser
);
	import isrt_pkg::*;

	// chain of cells
	cell_data_t data_vec  [MAX_ITEMS];
	logic       gt_vec    [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] valid_vec;
	cell_ctrl_t ctrl;

	// control
	logic   drain_q;       // list complete, emptying the chain
	logic   dropped_q;     // a value of this list was lost
	logic   accept;
	logic   full;
	logic   load_out;      // move cell 0 into the output register
	logic   drain_done;

	// output register
	logic   out_valid_q;
	value_t out_value_q;
	logic   out_last_q;
	logic   out_ovf_q;

	assign full          = valid_vec[MAX_ITEMS-1];
	assign s_axis_tready = !drain_q;
	assign accept        = s_axis_tvalid && !drain_q;

	// drain step whenever the output register is free or being emptied
	assign load_out   = drain_q && valid_vec[0] && (!out_valid_q || m_axis_tready);
	assign drain_done = drain_q && !valid_vec[0];

	assign ctrl.insert = accept && !full;
	assign ctrl.shift  = load_out;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
			cell_data_t left_d;
			cell_data_t right_d;
			logic       left_gt;

			if (gi == 0) begin : g_first
				// nothing below cell 0: a larger entry here takes the new value
				assign left_d  = '{value: '0, valid: 1'b0};
				assign left_gt = 1'b0;
			end else begin : g_mid
				assign left_d  = data_vec[gi-1];
				assign left_gt = gt_vec[gi-1];
			end

			if (gi == MAX_ITEMS - 1) begin : g_top
				// top cell empties as the chain shifts down
				assign right_d = '{value: '0, valid: 1'b0};
			end else begin : g_below
				assign right_d = data_vec[gi+1];
			end

			isrt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.din    (value_t'(s_axis_tdata)),
				.left   (left_d),
				.left_gt(left_gt),
				.right  (right_d),
				.gt     (gt_vec[gi]),
				.data   (data_vec[gi])
			);

			assign valid_vec[gi] = data_vec[gi].valid;
		end
	endgenerate

	// list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (drain_done) begin
				drain_q   <= 1'b0;
				dropped_q <= 1'b0;
			end else begin
				if (accept && s_axis_tlast) begin
					drain_q <= 1'b1;
				end
				if (accept && full) begin
					dropped_q <= 1'b1;
				end
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= data_vec[0].value;
			out_last_q  <= !valid_vec[1];
			out_ovf_q   <= dropped_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

	`ASSERT_NEVER(a_valid_contig, clk, arst_n, (valid_vec[MAX_ITEMS-1:1] & ~valid_vec[MAX_ITEMS-2:0]) != '0, "hole in the cell chain")
	`ASSERT_HOLDS(a_drop_flag, clk, arst_n, (accept && full && !s_axis_tlast) |=> dropped_q, "dropped value not flagged")
	`ASSERT_HOLDS(a_last_empty, clk, arst_n, (load_out && !valid_vec[1]) |=> !valid_vec[0], "chain not empty after final result")
	`ASSERT_HOLDS(a_drain_clear, clk, arst_n, drain_done |=> (!drain_q && !dropped_q), "list state not cleared after drain")

endmodule

// ===== verif/sort_checker.sv =====
// ---------------------------------------------------------------------------
// sort_checker
// watches both streams of the insertion sorter and checks every result
// ---------------------------------------------------------------------------
// Keeps its own sorted copy of the list being loaded. On the closing request
// it queues the whole list in ascending order. Each result on the master
// stream is then compared against the oldest queued entry.
// ---------------------------------------------------------------------------
module sort_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,      // value[31:0]
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,      // sorted_value[31:0]
	input  logic        m_axis_tlast,
	input  logic        m_axis_tuser,      // overflow
	output int          fail_count,
	output int          pending,
	output int          results_checked
);
	import isrt_pkg::*;

	typedef struct packed {
		value_t value;
		logic   last;
		logic   overflow;
	} sorted_result_t;

	value_t         sorted_copy [MAX_ITEMS];
	int             stored;
	logic           dropped;
	sorted_result_t sorted_q [$];

	// larger entries move up, the new value lands after any equal ones
	task automatic insert_value(input value_t v);
		int pos;
		pos = stored;
		while (pos > 0 && sorted_copy[pos-1] > v) begin
			sorted_copy[pos] = sorted_copy[pos-1];
			pos--;
		end
		sorted_copy[pos] = v;
		stored++;
	endtask

	task automatic note_mismatch(input string what, input sorted_result_t want);
		fail_count++;
		if (fail_count <= 10)
			$display("%s: expected value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
				what, want.value, want.last, want.overflow,
				$signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		sorted_result_t want;
		int k;
		if (!arst_n) begin
			sorted_q.delete();
			stored          = 0;
			dropped         = 1'b0;
			fail_count      = 0;
			results_checked = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (sorted_q.size() == 0) begin
					want = '0;
					note_mismatch("unexpected result", want);
				end else begin
					want = sorted_q.pop_front();
					if (m_axis_tdata !== want.value || m_axis_tlast !== want.last ||
							m_axis_tuser !== want.overflow)
						note_mismatch("result mismatch", want);
				end
				results_checked++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (stored < MAX_ITEMS)
					insert_value(value_t'(s_axis_tdata));
				else
					dropped = 1'b1;
				if (s_axis_tlast) begin
					for (k = 0; k < stored; k++) begin
						want.value    = sorted_copy[k];
						want.last     = (k == stored - 1);
						want.overflow = dropped;
						sorted_q.push_back(want);
					end
					stored  = 0;
					dropped = 1'b0;
				end
			end
		end
		pending = sorted_q.size();
	end

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// stimulus and verdict for the insertion sorter
// ---------------------------------------------------------------------------
// Streams lists of signed values into the sorter with random gaps, while the
// result side stalls at random. A directed part covers the value extremes,
// duplicates and one-element lists; the random part mixes short lists with a
// list that fills the store exactly and one that overflows it. All checking
// is done by sort_checker.
// ---------------------------------------------------------------------------
module testbench;
	import isrt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;         // value[31:0]
	logic        s_axis_tlast;         // last_in
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;         // sorted_value[31:0]
	logic        m_axis_tlast;         // last_out
	logic        m_axis_tuser;         // overflow

	int fail_count;
	int pending;
	int results_checked;
	int cycle_count = 0;
	int request_count = 0;
	int list_count = 0;
	bit src_quiet = 1'b0;

	always #5 clk = ~clk;

	insertion_sorter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	sort_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tlast    (m_axis_tlast),
		.m_axis_tuser    (m_axis_tuser),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// hard stop in case the handshakes hang
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
			$display("testbench NOT OK");
			$finish;
		end
	end

	// mix of small values (lots of duplicates), extremes and full-range values
	function automatic value_t draw_value();
		case ($urandom_range(0, 5))
			0, 1: return value_t'($urandom_range(0, 8)) - 4;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					default: return 32'shffff_ffff;
				endcase
			end
			default: return value_t'($urandom);
		endcase
	endfunction

	// one value request; valid stays high across back-to-back requests
	task automatic send_request(input value_t v, input logic last);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			// idle bus carries junk so nothing depends on data while valid is low
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			s_axis_tlast  <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		request_count++;
	endtask

	// random list of len values, the closing request flagged with tlast
	task automatic send_list(input int len);
		int i;
		src_quiet = ($urandom_range(0, 4) == 0);
		for (i = 0; i < len; i++)
			send_request(draw_value(), i == len - 1);
		list_count++;
	endtask

	// hold the sender off until every queued result has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		value_t mixed [10];
		int i;
		int random_start;
		mixed = '{32'sh0000_0000, 32'shffff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh0000_0005, 32'shffff_ffff, 32'sh0000_0005, 32'sh0000_0000,
			32'sh8000_0000, 32'sh0000_0003};

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-element lists at both ends of the range
		send_request(32'sh8000_0000, 1'b1);
		send_request(32'sh7fff_ffff, 1'b1);
		// extremes and duplicates in scrambled order
		for (i = 0; i < 10; i++)
			send_request(mixed[i], i == 9);
		list_count += 3;
		// equal pair, rising run, falling run
		send_request(-7, 1'b0);
		send_request(-7, 1'b1);
		for (i = 1; i <= 3; i++)
			send_request(i, i == 3);
		for (i = 3; i >= 1; i--)
			send_request(i, i == 1);
		list_count += 3;

		// random part: short lists around a full list and an overflowing one
		random_start = request_count;
		while (request_count - random_start < 10)
			send_list($urandom_range(1, 12));
		send_list(MAX_ITEMS);
		// sender waits here until the full list is out
		wait_drained();
		while (request_count - random_start < 80)
			send_list($urandom_range(1, 8));
		// three past capacity, the closing request among the dropped ones
		send_list(MAX_ITEMS + 3);
		while (request_count - random_start < 150)
			send_list($urandom_range(1, 12));

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d lists in %0d value requests, checked %0d sorted results",
			list_count, request_count, results_checked);
		$display("covered value extremes, duplicates, a full store and an overflowing list");
		if (fail_count == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// result side: random stalls per result, with quiet stretches now and then
	initial begin : sink
		int stall;
		bit quiet;
		m_axis_tready <= 1'b0;
		quiet = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				quiet = !quiet;
			stall = quiet ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/isrt_pkg.sv
hdl/isrt_cell.sv
hdl/insertion_sorter.sv
verif/sort_checker.sv
verif/testbench.sv
